>>> rtl/drive_command_decoder_mixer_top_assert.svh
// Assertion macros shared by the drive command decoder and mixer RTL
`ifndef DRIVE_COMMAND_DECODER_MIXER_TOP_ASSERT_SVH
`define DRIVE_COMMAND_DECODER_MIXER_TOP_ASSERT_SVH
`ifndef SYNTH
`define DCDM_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");
`define DCDM_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");
`else
`define DCDM_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define DCDM_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

>>> rtl/dcdm_pkg.sv
// Types, command codes and arithmetic helpers for the drive command decoder and mixer
`timescale 1ns / 1ps

package dcdm_pkg;

    localparam logic [7:0] CHR_LW    = 8'h77;
    localparam logic [7:0] CHR_LS    = 8'h73;
    localparam logic [7:0] CHR_UW    = 8'h57;
    localparam logic [7:0] CHR_US    = 8'h53;
    localparam logic [7:0] CHR_LD    = 8'h64;
    localparam logic [7:0] CHR_LA    = 8'h61;
    localparam logic [7:0] CHR_UD    = 8'h44;
    localparam logic [7:0] CHR_UA    = 8'h41;
    localparam logic [7:0] CHR_V     = 8'h76;
    localparam logic [7:0] CHR_SPACE = 8'h20;

    localparam logic [7:0] SPD_FWD      = 8'd180;
    localparam logic [7:0] SPD_REV      = 8'd74;
    localparam logic [7:0] SPD_FWD_FULL = 8'd255;
    localparam logic [7:0] SPD_REV_FULL = 8'd1;
    localparam logic [7:0] SPD_TURN_HI  = 8'd240;
    localparam logic [7:0] SPD_TURN_LO  = 8'd15;
    localparam logic [7:0] SPD_STOP     = 8'd128;
    localparam logic [7:0] SPD_MAX      = 8'd254;
    localparam logic [7:0] SPD_MIN      = 8'd1;

    localparam logic signed [15:0] MIX_OFFSET = 16'sd12700;
    localparam logic [14:0]        DIV_ROUND  = 15'd99;
    localparam logic [12:0]        RECIP_100  = 13'd5243;

    typedef struct packed {
        logic       set_left;
        logic [7:0] left_speed;
        logic       set_right;
        logic [7:0] right_speed;
        logic       restart_timer;
        logic       moving;
    } res_t;

    typedef struct packed {
        logic              joy;
        logic signed [7:0] x;
        logic signed [7:0] y;
        res_t              res;
    } job_t;

    // floor(u / 100) for u below 43000
    function automatic logic [8:0] div100(input logic [14:0] u);
        logic [27:0] prod;
        prod = 28'(u) * 28'(RECIP_100);
        return prod[27:19];
    endfunction

    function automatic logic [7:0] clamp_speed(input logic signed [10:0] s);
        logic [7:0] r;
        if (s >= 11'sd255)
            r = SPD_MAX;
        else if (s <= 11'sd0)
            r = SPD_MIN;
        else
            r = s[7:0];
        return r;
    endfunction

endpackage

>>> rtl/dcdm_decode.sv
// Command byte decoder: keyboard and joystick state and per-transaction job build
`timescale 1ns / 1ps
`include "drive_command_decoder_mixer_top_assert.svh"

module dcdm_decode
    import dcdm_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       accept,
    input  logic [7:0] rx_byte,
    input  logic       battery_fault,
    output job_t       job
);

    logic       joy_reg;
    logic       joy_next;
    logic       idx_reg;
    logic       idx_next;
    logic [7:0] held_y_reg;
    logic [7:0] held_y_next;
    logic       moving_reg;
    logic       moving_next;

    logic [7:0] neg_b;
    logic [7:0] neg_held_y;
    logic       x_nonpos;
    logic       kb_hit;
    logic [7:0] kb_left;
    logic [7:0] kb_right;

    assign neg_b      = 8'd0 - rx_byte;
    assign neg_held_y = 8'd0 - held_y_reg;
    assign x_nonpos   = neg_b[7] || (neg_b == 8'd0);

    always_comb
    begin
        kb_hit   = 1'b1;
        kb_left  = 8'd0;
        kb_right = 8'd0;
        case (rx_byte)
            CHR_LW:
            begin
                kb_left  = SPD_FWD;
                kb_right = SPD_FWD;
            end
            CHR_LS:
            begin
                kb_left  = SPD_REV;
                kb_right = SPD_REV;
            end
            CHR_UW:
            begin
                kb_left  = SPD_FWD_FULL;
                kb_right = SPD_FWD_FULL;
            end
            CHR_US:
            begin
                kb_left  = SPD_REV_FULL;
                kb_right = SPD_REV_FULL;
            end
            CHR_LD:
            begin
                kb_left  = SPD_TURN_HI;
                kb_right = SPD_TURN_LO;
            end
            CHR_LA:
            begin
                kb_left  = SPD_TURN_LO;
                kb_right = SPD_TURN_HI;
            end
            CHR_UD:
            begin
                kb_left  = SPD_FWD_FULL;
                kb_right = SPD_REV_FULL;
            end
            CHR_UA:
            begin
                kb_left  = SPD_REV_FULL;
                kb_right = SPD_FWD_FULL;
            end
            default:
            begin
                kb_hit = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        joy_next    = joy_reg;
        idx_next    = idx_reg;
        held_y_next = held_y_reg;
        moving_next = moving_reg;
        job         = '0;
        if (!battery_fault)
        begin
            if (joy_reg)
            begin
                if (!idx_reg)
                begin
                    held_y_next = neg_b;
                    idx_next    = 1'b1;
                end
                else
                begin
                    job.joy           = 1'b1;
                    job.x             = neg_b;
                    job.y             = x_nonpos ? neg_held_y : held_y_reg;
                    job.res.set_left  = 1'b1;
                    job.res.set_right = 1'b1;
                    idx_next          = 1'b0;
                    joy_next          = 1'b0;
                end
            end
            else if (kb_hit)
            begin
                job.res.set_left      = 1'b1;
                job.res.set_right     = 1'b1;
                job.res.left_speed    = kb_left;
                job.res.right_speed   = kb_right;
                job.res.restart_timer = 1'b1;
                moving_next           = 1'b1;
            end
            else if (rx_byte == CHR_V)
            begin
                job.res.restart_timer = 1'b1;
                joy_next              = 1'b1;
                idx_next              = 1'b0;
                moving_next           = 1'b1;
            end
            else if (rx_byte == CHR_SPACE)
            begin
                job.res.set_left    = 1'b1;
                job.res.set_right   = 1'b1;
                job.res.left_speed  = SPD_STOP;
                job.res.right_speed = SPD_STOP;
                moving_next         = 1'b0;
            end
        end
        job.res.moving = moving_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            joy_reg    <= 1'b0;
            idx_reg    <= 1'b0;
            held_y_reg <= 8'd0;
            moving_reg <= 1'b0;
        end
        else if (accept)
        begin
            joy_reg    <= joy_next;
            idx_reg    <= idx_next;
            held_y_reg <= held_y_next;
            moving_reg <= moving_next;
        end
    end

    `DCDM_ASSERT_IMP(a_idx_in_joy, clk, rst_n, idx_reg, joy_reg)
    `DCDM_ASSERT_NXT(a_fault_freezes, clk, rst_n, accept && battery_fault,
        $stable(joy_reg) && $stable(idx_reg) && $stable(held_y_reg) && $stable(moving_reg))

endmodule

>>> rtl/dcdm_mix.sv
// Joystick mixer: fixed-point speed mix and clamp for one transaction
`timescale 1ns / 1ps

module dcdm_mix
    import dcdm_pkg::*;
(
    input  job_t job,
    output res_t res
);

    logic signed [15:0] m;
    logic signed [15:0] m_neg;
    logic [14:0]        mag_m;
    logic signed [15:0] c;
    logic signed [15:0] c_neg;
    logic [14:0]        mag_c;
    logic [8:0]         q_a;
    logic [8:0]         q_lo;
    logic [8:0]         q_hi;
    logic signed [9:0]  a;
    logic signed [9:0]  fr;
    logic signed [9:0]  fl;
    logic signed [10:0] sum_r;
    logic signed [10:0] sum_l;

    assign m     = {job.x[7], job.x, 7'b0} + MIX_OFFSET;
    assign m_neg = -m;
    assign mag_m = m[15] ? m_neg[14:0] : m[14:0];

    assign c     = {job.y[7], job.y, 7'b0} - {{8{job.y[7]}}, job.y};
    assign c_neg = -c;
    assign mag_c = c[15] ? c_neg[14:0] : c[14:0];

    assign q_a  = div100(mag_m);
    assign q_lo = div100(mag_c);
    assign q_hi = div100(mag_c + DIV_ROUND);

    assign a  = m[15] ? -$signed({1'b0, q_a}) : $signed({1'b0, q_a});
    assign fr = c[15] ? -$signed({1'b0, q_hi}) : $signed({1'b0, q_lo});
    assign fl = c[15] ? $signed({1'b0, q_lo}) : -$signed({1'b0, q_hi});

    assign sum_r = {a[9], a} + {fr[9], fr};
    assign sum_l = {a[9], a} + {fl[9], fl};

    always_comb
    begin
        res = job.res;
        if (job.joy)
        begin
            res.left_speed  = clamp_speed(sum_l);
            res.right_speed = clamp_speed(sum_r);
        end
    end

endmodule

>>> rtl/drive_command_decoder_mixer_top.sv
// Top level of the drive command decoder and mixer
//
//  channel | valid     | stall     | payload
//  --------+-----------+-----------+--------------------------------------------
//  in      | in_valid  | in_stall  | rx_byte, battery_fault
//  out     | out_valid | out_stall | set_left, left_speed, set_right,
//          |           |           | right_speed, restart_timer, moving
//
//  One transaction per clock unless stalled; stages: job register, result register.
//  The mixer's three constant reciprocal multipliers set the job-to-result path.
//  rst_n clears decoder state and both stage valids; payload registers are not reset.
//  out_stall holds the result; in_stall rises only when both stages are full.
`timescale 1ns / 1ps
`include "drive_command_decoder_mixer_top_assert.svh"

module drive_command_decoder_mixer_top
    import dcdm_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] rx_byte,
    input  logic       battery_fault,
    output logic       out_valid,
    input  logic       out_stall,
    output logic       set_left,
    output logic [7:0] left_speed,
    output logic       set_right,
    output logic [7:0] right_speed,
    output logic       restart_timer,
    output logic       moving
);

    job_t job_in;
    job_t job_reg;
    res_t res_mix;
    res_t res_reg;

    logic job_valid_reg;
    logic job_valid_next;
    logic res_valid_reg;
    logic res_valid_next;
    logic job_load;
    logic res_advance;

    assign res_advance = job_valid_reg && (!res_valid_reg || !out_stall);
    assign in_stall    = job_valid_reg && !res_advance;
    assign job_load    = in_valid && !in_stall;

    dcdm_decode u_decode (
        .clk           (clk),
        .rst_n         (rst_n),
        .accept        (job_load),
        .rx_byte       (rx_byte),
        .battery_fault (battery_fault),
        .job           (job_in)
    );

    dcdm_mix u_mix (
        .job (job_reg),
        .res (res_mix)
    );

    always_comb
    begin
        job_valid_next = job_valid_reg;
        if (job_load)
            job_valid_next = 1'b1;
        else if (res_advance)
            job_valid_next = 1'b0;

        res_valid_next = res_valid_reg;
        if (res_advance)
            res_valid_next = 1'b1;
        else if (!out_stall)
            res_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            job_valid_reg <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            job_valid_reg <= job_valid_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (job_load)
            job_reg <= job_in;
        if (res_advance)
            res_reg <= res_mix;
    end

    assign out_valid     = res_valid_reg;
    assign set_left      = res_reg.set_left;
    assign left_speed    = res_reg.left_speed;
    assign set_right     = res_reg.set_right;
    assign right_speed   = res_reg.right_speed;
    assign restart_timer = res_reg.restart_timer;
    assign moving        = res_reg.moving;

    `DCDM_ASSERT_NXT(a_joy_in_range, clk, rst_n, res_advance && job_reg.joy,
        set_left && set_right && left_speed != 8'd0 && left_speed != 8'd255
        && right_speed != 8'd0 && right_speed != 8'd255)
    `DCDM_ASSERT_IMP(a_restart_moving, clk, rst_n, out_valid && restart_timer, moving)
    `DCDM_ASSERT_IMP(a_stall_full, clk, rst_n, in_stall, job_valid_reg && res_valid_reg && out_stall)
    `DCDM_ASSERT_IMP(a_sets_paired, clk, rst_n, out_valid, set_left == set_right)

endmodule
